@@ hw/rtl/bchc_pkg.sv @@
// ----------------------------------------------------------------------------
// bchc_pkg
// Types and constants shared by the button click/hold classifier modules.
// ----------------------------------------------------------------------------
package bchc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int TIME_W     = 32;
    localparam int STUCK_W    = 15;

    localparam logic [STUCK_W-1:0] STUCK_LIMIT_MS = 15'd15000;
    localparam logic [STUCK_W-1:0] SOS_REPEAT_MS  = 15'd2000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_DB   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DB = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOS_TIME   = 2'd3;

    typedef enum logic [1:0] {
        GEST_NONE  = 2'd0,
        GEST_CLICK = 2'd1,
        GEST_HOLD  = 2'd2,
        GEST_SOS   = 2'd3
    } gesture_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] press_db;
        logic [CFG_DATA_W-1:0] release_db;
        logic [CFG_DATA_W-1:0] hold_time;
        logic [CFG_DATA_W-1:0] sos_time;
    } cfg_t;

    typedef struct packed {
        logic              button_released;
        logic [TIME_W-1:0] time_now;
        logic              link_authorized;
        logic              powered_up;
        logic              display_off;
    } item_t;

    typedef struct packed {
        gesture_t gesture;
        logic     request_restart;
        logic     arm_power_down;
        logic     wake_display;
        logic     start_clock;
        logic     invalid_touch;
    } result_t;

endpackage

@@ hw/rtl/bchc_cfg.sv @@
// ----------------------------------------------------------------------------
// bchc_cfg
// Configuration register file: four 16-bit timing registers, write only.
// ----------------------------------------------------------------------------
module bchc_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bchc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bchc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output bchc_pkg::cfg_t                      cfg
);
    import bchc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PRESS_DB:   cfg_next.press_db   = cfg_data;
                REG_RELEASE_DB: cfg_next.release_db = cfg_data;
                REG_HOLD_TIME:  cfg_next.hold_time  = cfg_data;
                REG_SOS_TIME:   cfg_next.sos_time   = cfg_data;
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_db   <= 16'd50;
            cfg_reg.release_db <= 16'd50;
            cfg_reg.hold_time  <= 16'd3000;
            cfg_reg.sos_time   <= 16'd8000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/bchc_step.sv @@
// ----------------------------------------------------------------------------
// bchc_step
// Classifier state and the combinational edge and classify logic.
// ----------------------------------------------------------------------------
module bchc_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  bchc_pkg::item_t   item,
    input  bchc_pkg::cfg_t    cfg,
    output bchc_pkg::result_t res
);
    import bchc_pkg::*;

    logic               stable_released_reg, stable_released_next;
    logic               sampled_released_reg, sampled_released_next;
    logic [TIME_W-1:0]  press_time_reg, press_time_next;
    logic [TIME_W-1:0]  release_time_reg, release_time_next;
    logic               half_click_reg, half_click_next;
    logic               stuck_reg, stuck_next;
    logic [STUCK_W-1:0] stuck_counter_reg, stuck_counter_next;

    logic [TIME_W-1:0]  held;
    logic [TIME_W-1:0]  since_release;
    logic [TIME_W-1:0]  press_len;
    logic               release_path;

    always_comb
    begin
        stable_released_next  = stable_released_reg;
        sampled_released_next = sampled_released_reg;
        press_time_next       = press_time_reg;
        release_time_next     = release_time_reg;
        half_click_next       = half_click_reg;
        stuck_next            = stuck_reg;
        stuck_counter_next    = stuck_counter_reg;
        res                   = '0;
        res.gesture           = GEST_NONE;
        release_path          = 1'b0;

        // edge step: a released sample clears the stuck latch
        if (item.button_released)
        begin
            stuck_next         = 1'b0;
            stuck_counter_next = '0;
        end
        if (item.button_released != sampled_released_reg)
        begin
            sampled_released_next = item.button_released;
            if (item.button_released)
            begin
                release_time_next = item.time_now;
            end
            else
            begin
                press_time_next    = item.time_now;
                res.wake_display   = item.link_authorized;
                res.invalid_touch  = item.link_authorized & item.display_off;
                res.start_clock    = ~item.link_authorized;
            end
        end

        held          = item.time_now - press_time_next;
        since_release = item.time_now - release_time_next;
        press_len     = release_time_next - press_time_next;

        // classify step
        if (!stuck_next)
        begin
            priority if (stable_released_reg == sampled_released_next && !sampled_released_next)
            begin
                if (stuck_counter_next >= STUCK_LIMIT_MS)
                begin
                    stuck_next = 1'b1;
                end
                else if (held >= {16'd0, cfg.sos_time} && item.link_authorized)
                begin
                    press_time_next    = press_time_next + TIME_W'(SOS_REPEAT_MS);
                    stuck_counter_next = stuck_counter_next + SOS_REPEAT_MS;
                    res.gesture        = GEST_SOS;
                end
            end
            else if (!sampled_released_next)
            begin
                if (held >= {16'd0, cfg.press_db})
                begin
                    if (held >= {16'd0, cfg.hold_time})
                    begin
                        stable_released_next = 1'b0;
                        half_click_next      = 1'b0;
                        res.gesture          = GEST_HOLD;
                        res.request_restart  = ~item.powered_up;
                        res.arm_power_down   = item.powered_up;
                    end
                    else
                    begin
                        half_click_next = 1'b1;
                    end
                end
            end
            else
            begin
                release_path = 1'b1;
            end
        end

        // released: evaluate the last press once the release has settled
        if (release_path && since_release >= {16'd0, cfg.release_db}
            && press_len >= {16'd0, cfg.press_db})
        begin
            if (half_click_reg && press_len < {16'd0, cfg.hold_time})
            begin
                half_click_next = 1'b0;
                res.gesture     = GEST_CLICK;
            end
            else
            begin
                stable_released_next = 1'b1;
                half_click_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_released_reg  <= 1'b1;
            sampled_released_reg <= 1'b1;
            press_time_reg       <= '0;
            release_time_reg     <= '0;
            half_click_reg       <= 1'b0;
            stuck_reg            <= 1'b0;
            stuck_counter_reg    <= '0;
        end
        else if (fire)
        begin
            stable_released_reg  <= stable_released_next;
            sampled_released_reg <= sampled_released_next;
            press_time_reg       <= press_time_next;
            release_time_reg     <= release_time_next;
            half_click_reg       <= half_click_next;
            stuck_reg            <= stuck_next;
            stuck_counter_reg    <= stuck_counter_next;
        end
    end

endmodule

@@ hw/rtl/button_click_hold_classifier.sv @@
// ----------------------------------------------------------------------------
// button_click_hold_classifier
// Debounces button samples and reports click, hold, SOS and wake events.
// ----------------------------------------------------------------------------
// Pipeline: input register, then the classify logic into the result
//   register.
// Throughput: one item per cycle while result_ready does not stall the result.
// Reset: asynchronous, clears the valid flags of both stages and loads the
//   button state as released and the timing registers with their defaults.
module button_click_hold_classifier (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bchc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bchc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  logic                             button_released,
    input  logic [bchc_pkg::TIME_W-1:0]      time_now,
    input  logic                             link_authorized,
    input  logic                             powered_up,
    input  logic                             display_off,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic [1:0]                       gesture,
    output logic                             request_restart,
    output logic                             arm_power_down,
    output logic                             wake_display,
    output logic                             start_clock,
    output logic                             invalid_touch
);
    import bchc_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t res;
    result_t res_reg;
    logic    res_valid_reg;
    logic    out_free;
    logic    fire;

    assign out_free   = ~res_valid_reg | result_ready;
    assign fire       = item_valid_reg & out_free;
    assign item_ready = ~item_valid_reg | fire;

    bchc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bchc_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg.button_released <= button_released;
            item_reg.time_now        <= time_now;
            item_reg.link_authorized <= link_authorized;
            item_reg.powered_up      <= powered_up;
            item_reg.display_off     <= display_off;
        end
    end

    // result stage: hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            res_valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res;
        end
    end

    assign result_valid    = res_valid_reg;
    assign gesture         = res_reg.gesture;
    assign request_restart = res_reg.request_restart;
    assign arm_power_down  = res_reg.arm_power_down;
    assign wake_display    = res_reg.wake_display;
    assign start_clock     = res_reg.start_clock;
    assign invalid_touch   = res_reg.invalid_touch;

endmodule

@@ hw/rtl/bchc_checker.sv @@
// ----------------------------------------------------------------------------
// bchc_checker
// Port-level checks for the button click/hold classifier.
// ----------------------------------------------------------------------------
module bchc_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bchc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bchc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             item_valid,
    input  logic                             item_ready,
    input  logic                             button_released,
    input  logic [bchc_pkg::TIME_W-1:0]      time_now,
    input  logic                             link_authorized,
    input  logic                             powered_up,
    input  logic                             display_off,
    input  logic                             result_valid,
    input  logic                             result_ready,
    input  logic [1:0]                       gesture,
    input  logic                             request_restart,
    input  logic                             arm_power_down,
    input  logic                             wake_display,
    input  logic                             start_clock,
    input  logic                             invalid_touch
);
    import bchc_pkg::*;

    // a stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(gesture)
        && $stable(wake_display) && $stable(start_clock))
        else $error("result changed while stalled");

    // restart or power-down only come with a hold, never both
    a_hold_action: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (request_restart || arm_power_down) |->
        gesture == GEST_HOLD && !(request_restart && arm_power_down))
        else $error("hold action without a single hold gesture");

    // an invalid touch is part of a display wake
    a_invalid_wake: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && invalid_touch |-> wake_display)
        else $error("invalid touch without wake");

    // a press edge either wakes the display or starts the clock
    a_wake_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(wake_display && start_clock))
        else $error("wake and start clock together");

endmodule

bind button_click_hold_classifier bchc_checker u_bchc_checker (.*);
